// ----- rtl/core/event_ring_log_defines.svh -----
// Assertion macros for the event ring log checker.
`ifndef EVENT_RING_LOG_DEFINES_SVH
`define EVENT_RING_LOG_DEFINES_SVH

// Clocked assertion with a synchronous reset that disables it.
`define ELOG_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block clock and reset by their usual names.
`define ELOG_ASSERT(lbl, prop, msg) \
  `ELOG_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

// ----- rtl/core/elog_pkg.sv -----
// Types and codes shared by the event ring log modules.
package elog_pkg;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DISABLED = 2'd1,
    STATUS_NO_AGE   = 2'd2
  } status_t;

  localparam int unsigned AGE_W = 5;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [7:0]  code;
    logic [31:0] detail;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic        read_hit;
    logic [31:0] total;
  } pend_t;

endpackage

// ----- rtl/core/event_ring_log.sv -----
// Top level of the event ring log.
// Result path: an accepted transaction is registered in pend_valid and the pending
// fields, then in done and the result outputs, where it shows with done high.
// Busy covers the memory read cycle; no new transaction is accepted while busy is high.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset (rst, synchronous): clears pointer, event count, log_enable and strobes;
// entry memory is not cleared and its read data is only returned where it was written.
module event_ring_log #(
  parameter int unsigned LOG_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] timestamp,
  input  logic [7:0]  event_code,
  input  logic [31:0] event_detail,
  input  logic [4:0]  age_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_timestamp,
  output logic [7:0]  out_code,
  output logic [31:0] out_detail,
  output logic [31:0] total_events
);

  localparam int unsigned PW = $clog2(LOG_DEPTH);

  logic             accept;
  logic             mem_we;
  logic [PW-1:0]    mem_waddr;
  logic [PW-1:0]    mem_raddr;
  elog_pkg::entry_t mem_wdata;
  elog_pkg::entry_t mem_rdata;

  assign accept = start && !busy;

  assign mem_wdata.timestamp = timestamp;
  assign mem_wdata.code      = event_code;
  assign mem_wdata.detail    = event_detail;

  elog_ctrl #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .opcode       (opcode),
    .age_index    (age_index),
    .pending      (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .done         (done),
    .status       (status),
    .out_timestamp(out_timestamp),
    .out_code     (out_code),
    .out_detail   (out_detail),
    .total_events (total_events)
  );

  elog_mem #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ----- rtl/core/elog_mem.sv -----
// Entry memory: one write port, one registered read port.
module elog_mem #(
  parameter int unsigned LOG_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(LOG_DEPTH)-1:0] waddr,
  input  elog_pkg::entry_t             wdata,
  input  logic [$clog2(LOG_DEPTH)-1:0] raddr,
  output elog_pkg::entry_t             rdata
);

  elog_pkg::entry_t mem [LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/elog_ctrl.sv -----
// Control: enable register, write pointer, event count, slot lookup and result stage.
module elog_ctrl #(
  parameter int unsigned LOG_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          accept,
  input  logic                          opcode,
  input  logic [elog_pkg::AGE_W-1:0]    age_index,
  output logic                          pending,
  output logic                          mem_we,
  output logic [$clog2(LOG_DEPTH)-1:0]  mem_waddr,
  output logic [$clog2(LOG_DEPTH)-1:0]  mem_raddr,
  input  elog_pkg::entry_t              mem_rdata,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [31:0]                   out_timestamp,
  output logic [7:0]                    out_code,
  output logic [31:0]                   out_detail,
  output logic [31:0]                   total_events
);

  localparam int unsigned PW = $clog2(LOG_DEPTH);
  localparam int unsigned SW = ((PW > elog_pkg::AGE_W) ? PW : elog_pkg::AGE_W) + 2;
  localparam int unsigned CW = ((PW > elog_pkg::AGE_W) ? PW : elog_pkg::AGE_W) + 1;

  logic                 log_enable;
  logic [PW-1:0]        wp;
  logic [PW-1:0]        wp_next;
  logic [31:0]          event_total;
  logic [31:0]          total_next;
  logic                 record;
  logic                 avail;
  logic [SW-1:0]        diff;
  logic [SW-1:0]        slot;
  logic                 pend_valid;
  elog_pkg::pend_t      pend;
  elog_pkg::pend_t      pend_next;

  assign record    = accept && log_enable && (opcode == elog_pkg::OP_RECORD);
  assign wp_next   = (wp == PW'(LOG_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign total_next = (event_total == 32'hFFFF_FFFF) ? event_total : event_total + 32'd1;

  assign avail = (32'(age_index) < event_total) &&
                 (CW'(age_index) < CW'(LOG_DEPTH));
  assign diff  = SW'(wp) + SW'(LOG_DEPTH - 1) - SW'(age_index);
  assign slot  = (diff >= SW'(LOG_DEPTH)) ? diff - SW'(LOG_DEPTH) : diff;

  assign mem_we    = record;
  assign mem_waddr = wp;
  assign mem_raddr = slot[PW-1:0];
  assign pending   = pend_valid;

  always_comb begin
    pend_next.read_hit = 1'b0;
    pend_next.total    = '0;
    pend_next.status   = elog_pkg::STATUS_DISABLED;
    if (log_enable) begin
      if (opcode == elog_pkg::OP_RECORD) begin
        pend_next.status = elog_pkg::STATUS_OK;
        pend_next.total  = total_next;
      end else begin
        pend_next.total = event_total;
        if (avail) begin
          pend_next.status   = elog_pkg::STATUS_OK;
          pend_next.read_hit = 1'b1;
        end else begin
          pend_next.status = elog_pkg::STATUS_NO_AGE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_enable  <= 1'b0;
      wp          <= '0;
      event_total <= '0;
      pend_valid  <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        log_enable <= cfg_wdata;
      end
      if (record) begin
        wp          <= wp_next;
        event_total <= total_next;
      end
      pend_valid <= accept;
      done       <= pend_valid;
    end
  end

  // hold the transaction's result fields until the memory data returns, then register the outputs
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
    if (pend_valid) begin
      status       <= pend.status;
      total_events <= pend.total;
      if (pend.read_hit) begin
        out_timestamp <= mem_rdata.timestamp;
        out_code      <= mem_rdata.code;
        out_detail    <= mem_rdata.detail;
      end else begin
        out_timestamp <= '0;
        out_code      <= '0;
        out_detail    <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/elog_checker.sv -----
// Port-level checker for the event ring log, bound to the top level.
`include "event_ring_log_defines.svh"

module elog_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] out_timestamp,
  input logic [7:0]  out_code,
  input logic [31:0] out_detail,
  input logic [31:0] total_events
);

  `ELOG_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy low after an accepted transaction")
  `ELOG_ASSERT(a_accept_done, (start && !busy) |-> ##2 done, "result strobe missing two edges after accept")
  `ELOG_ASSERT(a_refused_zero, (done && status != elog_pkg::STATUS_OK) |-> (out_timestamp == 32'd0 && out_code == 8'd0 && out_detail == 32'd0), "refused transaction returned entry data")
  `ELOG_ASSERT(a_disabled_total, (done && status == elog_pkg::STATUS_DISABLED) |-> (total_events == 32'd0), "disabled result carries a nonzero count")

endmodule

bind event_ring_log elog_checker u_elog_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .out_timestamp(out_timestamp),
  .out_code     (out_code),
  .out_detail   (out_detail),
  .total_events (total_events)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the event ring log: directed and random record/read traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LOG_DEPTH = 32;

  typedef struct {
    elog_pkg::status_t status;
    logic [31:0]       ts;
    logic [7:0]        code;
    logic [31:0]       detail;
    logic [31:0]       total;
  } log_answer_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [31:0] timestamp;
  logic [7:0]  event_code;
  logic [31:0] event_detail;
  logic [4:0]  age_index;
  logic        done;
  logic [1:0]  status;
  logic [31:0] out_timestamp;
  logic [7:0]  out_code;
  logic [31:0] out_detail;
  logic [31:0] total_events;

  logic [31:0] ring_time [LOG_DEPTH];
  logic [7:0]  ring_code [LOG_DEPTH];
  logic [31:0] ring_detail [LOG_DEPTH];
  int unsigned ring_head;
  logic [31:0] evt_total;
  bit          log_on;
  log_answer_t log_answers[$];
  int          fail_count = 0;

  always #5 clk = ~clk;

  event_ring_log #(.LOG_DEPTH(LOG_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .timestamp(timestamp),
    .event_code(event_code),
    .event_detail(event_detail),
    .age_index(age_index),
    .done(done),
    .status(status),
    .out_timestamp(out_timestamp),
    .out_code(out_code),
    .out_detail(out_detail),
    .total_events(total_events)
  );

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 50) begin
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic log_apply(elog_pkg::opcode_t op, logic [31:0] ts, logic [7:0] code,
                           logic [31:0] det, logic [4:0] age);
    log_answer_t a;
    int unsigned avail;
    int unsigned slot;
    a.status = elog_pkg::STATUS_DISABLED;
    a.ts = '0;
    a.code = '0;
    a.detail = '0;
    a.total = '0;
    if (log_on) begin
      if (op == elog_pkg::OP_RECORD) begin
        ring_time[ring_head] = ts;
        ring_code[ring_head] = code;
        ring_detail[ring_head] = det;
        ring_head = (ring_head + 1) % LOG_DEPTH;
        if (evt_total != 32'hFFFF_FFFF) begin
          evt_total++;
        end
        a.status = elog_pkg::STATUS_OK;
        a.total = evt_total;
      end else begin
        avail = (evt_total < LOG_DEPTH) ? evt_total : LOG_DEPTH;
        a.total = evt_total;
        if (age >= avail) begin
          a.status = elog_pkg::STATUS_NO_AGE;
        end else begin
          slot = (ring_head + LOG_DEPTH - 1 - age) % LOG_DEPTH;
          a.status = elog_pkg::STATUS_OK;
          a.ts = ring_time[slot];
          a.code = ring_code[slot];
          a.detail = ring_detail[slot];
        end
      end
    end
    log_answers.push_back(a);
  endtask

  always @(posedge clk) begin
    log_answer_t want;
    if (!rst && done) begin
      if (log_answers.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, status}, '0);
      end else begin
        want = log_answers.pop_front();
        if (status !== want.status) report_mismatch("status", {30'd0, status},
                                                    {30'd0, want.status});
        if (out_timestamp !== want.ts) report_mismatch("out_timestamp", out_timestamp,
                                                       want.ts);
        if (out_code !== want.code) report_mismatch("out_code", {24'd0, out_code},
                                                    {24'd0, want.code});
        if (out_detail !== want.detail) report_mismatch("out_detail", out_detail,
                                                        want.detail);
        if (total_events !== want.total) report_mismatch("total_events", total_events,
                                                         want.total);
      end
    end
  end

  task automatic log_item(elog_pkg::opcode_t op, logic [31:0] ts, logic [7:0] code,
                          logic [31:0] det, logic [4:0] age);
    start <= 1'b1;
    opcode <= op;
    timestamp <= ts;
    event_code <= code;
    event_detail <= det;
    age_index <= age;
    do @(posedge clk); while (busy);
    log_apply(op, ts, code, det, age);
  endtask

  task automatic pause(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_log();
    start <= 1'b0;
    while (log_answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_log_on(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    log_on = v;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_disabled_refusal();
    log_item(elog_pkg::OP_RECORD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd31);
    drain_log();
  endtask

  task automatic test_empty_reads();
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    log_item(elog_pkg::OP_READ, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    drain_log();
  endtask

  task automatic test_record_and_read();
    log_item(elog_pkg::OP_RECORD, '0, '0, '0, 5'd31);
    log_item(elog_pkg::OP_RECORD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    log_item(elog_pkg::OP_RECORD, 32'hA5A5_5A5A, 8'h5A, 32'h0F0F_F0F0, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd1);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd2);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd3);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd31);
    drain_log();
  endtask

  task automatic test_disable_keeps_state();
    set_log_on(1'b0);
    log_item(elog_pkg::OP_RECORD, 32'h1234_5678, 8'h3C, 32'h8765_4321, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    drain_log();
    set_log_on(1'b1);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    log_item(elog_pkg::OP_RECORD, 32'h0000_0001, 8'h01, 32'h8000_0000, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd0);
    log_item(elog_pkg::OP_READ, '0, '0, '0, 5'd3);
    drain_log();
  endtask

  task automatic random_traffic(int n);
    int burst_left;
    int unsigned avail;
    logic [4:0] age;
    elog_pkg::opcode_t op;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 39) == 0) drain_log();
        else pause($urandom_range(0, 5));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      op = $urandom_range(0, 1) ? elog_pkg::OP_READ : elog_pkg::OP_RECORD;
      avail = (evt_total < LOG_DEPTH) ? evt_total : LOG_DEPTH;
      if (avail != 0 && $urandom_range(0, 3) != 0) age = 5'($urandom_range(0, avail - 1));
      else age = 5'($urandom);
      log_item(op, pick_word(), 8'(pick_word()), pick_word(), age);
    end
    drain_log();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    start = 1'b0;
    opcode = 1'b0;
    timestamp = '0;
    event_code = '0;
    event_detail = '0;
    age_index = '0;
    ring_head = 0;
    evt_total = '0;
    log_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_disabled_refusal();
    set_log_on(1'b1);
    test_empty_reads();
    test_record_and_read();
    test_disable_keeps_state();
    random_traffic(450);
    set_log_on(1'b0);
    random_traffic(80);
    set_log_on(1'b1);
    random_traffic(550);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/elog_pkg.sv
rtl/core/elog_mem.sv
rtl/core/elog_ctrl.sv
rtl/core/event_ring_log.sv
rtl/core/elog_checker.sv
sim/testbench.sv
